@@ hw/rtl/aes128_pkg.sv @@
// Shared types, constants and AES helper functions for the AES-128 block-mode core.
package aes128_pkg;

  localparam int BlockW = 128;
  localparam int HalfW  = 64;
  localparam int Rounds = 10;
  localparam int CfbBytes = 16;
  localparam int CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CFB = 2'd2
  } mode_t;

  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HI = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LO = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IV_HI  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IV_LO  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_PASS_DONE,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch input request
    logic load;       // start one AES pass: whitening, key reload
    logic round;      // do one round
    logic pass_done;  // fold pass result into ct / chain
    logic out_valid;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_round;
    logic cfb_last;   // last CFB byte done after this pass
    logic is_cfb;
  } sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ hw/rtl/aes128_ctrl.sv @@
// Sequencer for the AES-128 block-mode core: passes, rounds and handshakes.
module aes128_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  aes128_pkg::sts_t  sts,
  output aes128_pkg::cmd_t  cmd
);

  aes128_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes128_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      aes128_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt = aes128_pkg::ST_LOAD;
        end
      end
      aes128_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        state_nxt = aes128_pkg::ST_ROUND;
      end
      aes128_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.last_round) state_nxt = aes128_pkg::ST_PASS_DONE;
      end
      aes128_pkg::ST_PASS_DONE: begin
        cmd.pass_done = 1'b1;
        if (sts.is_cfb && !sts.cfb_last) state_nxt = aes128_pkg::ST_LOAD;
        else state_nxt = aes128_pkg::ST_OUT;
      end
      aes128_pkg::ST_OUT: begin
        cmd.out_valid = 1'b1;
        if (out_tready) state_nxt = aes128_pkg::ST_IDLE;
      end
      default: state_nxt = aes128_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/aes128_dp.sv @@
// Datapath: config registers, chaining register, one AES round and one key-schedule step.
module aes128_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [aes128_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [aes128_pkg::HalfW-1:0]         cfg_data,
  input  logic [aes128_pkg::BlockW-1:0]        in_block,
  input  logic                                 in_som,
  input  aes128_pkg::cmd_t                     cmd,
  output aes128_pkg::sts_t                     sts,
  output logic [aes128_pkg::BlockW-1:0]        ct
);

  logic [1:0]   mode_r;
  logic [127:0] key_r, iv_r, chain_r, pt_r, ct_r, st_r, rk_r;
  logic [3:0]   rnd_r;
  logic [7:0]   rcon_r;
  logic [3:0]   byte_r;

  // bytes: byte 0 is bits [127:120]
  function automatic logic [7:0] gb(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

  logic [127:0] sr, mc, rnd_out, rk_nxt, pass_in;
  logic [31:0]  w3, tw;
  logic [7:0]   ctb;

  always_comb begin
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        sr[127-8*(r+4*c) -: 8] = aes128_pkg::sbox(gb(st_r, r + 4*((c+r)&3)));
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = gb(sr, 4*c); a1 = gb(sr, 4*c+1); a2 = gb(sr, 4*c+2); a3 = gb(sr, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 32] = {a0 ^ al ^ aes128_pkg::xtime(a0 ^ a1),
                            a1 ^ al ^ aes128_pkg::xtime(a1 ^ a2),
                            a2 ^ al ^ aes128_pkg::xtime(a2 ^ a3),
                            a3 ^ al ^ aes128_pkg::xtime(a3 ^ a0)};
    end
    w3 = rk_r[31:0];
    tw = {aes128_pkg::sbox(w3[23:16]) ^ rcon_r, aes128_pkg::sbox(w3[15:8]),
          aes128_pkg::sbox(w3[7:0]), aes128_pkg::sbox(w3[31:24])};
    rk_nxt[127:96] = rk_r[127:96] ^ tw;
    rk_nxt[95:64]  = rk_r[95:64] ^ rk_nxt[127:96];
    rk_nxt[63:32]  = rk_r[63:32] ^ rk_nxt[95:64];
    rk_nxt[31:0]   = rk_r[31:0]  ^ rk_nxt[63:32];
    rnd_out = ((rnd_r == 4'(aes128_pkg::Rounds)) ? sr : mc) ^ rk_nxt;
    case (mode_r)
      aes128_pkg::MODE_CBC: pass_in = pt_r ^ chain_r;
      aes128_pkg::MODE_CFB: pass_in = chain_r;
      default:              pass_in = pt_r;
    endcase
    ctb = gb(pt_r, 32'(byte_r)) ^ st_r[127:120];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd0;
      key_r   <= '0;
      iv_r    <= '0;
      chain_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          aes128_pkg::CFG_MODE:   mode_r <= cfg_data[1:0];
          aes128_pkg::CFG_KEY_HI: key_r[127:64] <= cfg_data;
          aes128_pkg::CFG_KEY_LO: key_r[63:0]   <= cfg_data;
          aes128_pkg::CFG_IV_HI:  iv_r[127:64]  <= cfg_data;
          aes128_pkg::CFG_IV_LO:  iv_r[63:0]    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept && in_som) chain_r <= iv_r;
      if (cmd.pass_done) begin
        if (mode_r == aes128_pkg::MODE_CBC) chain_r <= st_r;
        else if (mode_r == aes128_pkg::MODE_CFB) chain_r <= {chain_r[119:0], ctb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pt_r   <= in_block;
      byte_r <= '0;
    end
    if (cmd.load) begin
      st_r   <= pass_in ^ key_r;
      rk_r   <= key_r;
      rcon_r <= 8'h01;
      rnd_r  <= 4'd1;
    end
    if (cmd.round) begin
      st_r   <= rnd_out;
      rk_r   <= rk_nxt;
      rcon_r <= aes128_pkg::xtime(rcon_r);
      rnd_r  <= rnd_r + 4'd1;
    end
    if (cmd.pass_done) begin
      if (mode_r == aes128_pkg::MODE_CFB) begin
        ct_r   <= {ct_r[119:0], ctb};
        byte_r <= byte_r + 4'd1;
      end else begin
        ct_r <= st_r;
      end
    end
  end

  assign sts.last_round = (rnd_r == 4'(aes128_pkg::Rounds));
  assign sts.cfb_last   = (byte_r == 4'(aes128_pkg::CfbBytes - 1));
  assign sts.is_cfb     = (mode_r == aes128_pkg::MODE_CFB);
  assign ct = ct_r;

endmodule

@@ hw/rtl/aes128_block_mode_encrypt_core.sv @@
// Top level of the AES-128 ECB / CBC / CFB-8 encryption core.
// Channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata = block_hi, block_lo; tuser = start_of_message
// out_    | out | out_tvalid/out_tready| tdata = cipher_hi, cipher_lo
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index (3 b), cfg_data (64 b)
// ECB and CBC: each block steps through accept, load, 10 rounds (one round unit, round
// keys made on the fly), a fold and an output state; the result request is
// held on out_ until taken.
// CFB-8: 16 passes of load, 10 rounds and fold per block, all through the one round unit.
// rst_n is synchronous; config and chaining value clear to zero.
// One request at a time: in_tready is low from accept until the result is taken.
module aes128_block_mode_encrypt_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] block_hi, [127:64] block_lo
  input  logic         in_tuser,   // start_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] cipher_hi, [127:64] cipher_lo
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  aes128_pkg::cmd_t cmd;
  aes128_pkg::sts_t sts;
  logic [127:0]     in_block;  // byte 0 in [127:120]
  logic [127:0]     ct_block;  // byte 0 in [127:120]

  aes128_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tready, .sts, .cmd
  );

  // bus packs the hi half in the low bits; datapath keeps byte 0 on top
  assign in_block = {in_tdata[63:0], in_tdata[127:64]};

  aes128_dp u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_block (in_block), .in_som (in_tuser), .cmd, .sts, .ct (ct_block)
  );

  assign out_tdata  = {ct_block[63:0], ct_block[127:64]};
  assign cfg_ready  = 1'b1;
  assign out_tvalid = cmd.out_valid;

endmodule

@@ tb/aes128_block_mode_encrypt_core_test.sv @@
// Self-checking testbench of the AES-128 ECB / CBC / CFB-8 encryption core.
`timescale 1ns / 100ps

package aes128_tb_model_pkg;

  localparam logic [2047:0] SUB_BYTES_LUT = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};
  localparam logic [79:0] ROUND_CONST = 80'h01020408102040801b36;

  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    return SUB_BYTES_LUT[2047 - 8 * a -: 8];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES-128 encryption; byte 0 of the block sits in bits [127:120].
  function automatic logic [127:0] cipher_block128(input logic [127:0] pt,
                                                   input logic [127:0] key);
    logic [31:0]  w [44];
    logic [31:0]  tw;
    logic [127:0] rk;
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32 * i -: 32];
    for (int i = 4; i < 44; i++) begin
      tw = w[i - 1];
      if (i % 4 == 0) begin
        tw = {sub_byte(tw[23:16]) ^ ROUND_CONST[79 - 8 * (i / 4 - 1) -: 8],
              sub_byte(tw[15:8]), sub_byte(tw[7:0]), sub_byte(tw[31:24])};
      end
      w[i] = w[i - 4] ^ tw;
    end
    rk = {w[0], w[1], w[2], w[3]};
    for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ rk[127 - 8 * i -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r + 4 * c] = sub_byte(s[r + 4 * ((c + r) & 3)]);
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
          t[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
          t[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
          t[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      rk = {w[4 * rnd], w[4 * rnd + 1], w[4 * rnd + 2], w[4 * rnd + 3]};
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[127 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  class cipher_scoreboard;
    logic [1:0]   mode;
    logic [127:0] key;
    logic [127:0] iv;
    logic [127:0] chain;
    logic [127:0] pending_cipher [$];
    int           errors;

    function new();
      mode = aes128_pkg::MODE_ECB; key = '0; iv = '0; chain = '0; errors = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [63:0] data);
      case (idx)
        aes128_pkg::CFG_MODE:   mode = data[1:0];
        aes128_pkg::CFG_KEY_HI: key[127:64] = data;
        aes128_pkg::CFG_KEY_LO: key[63:0] = data;
        aes128_pkg::CFG_IV_HI:  iv[127:64] = data;
        aes128_pkg::CFG_IV_LO:  iv[63:0] = data;
        default: ;
      endcase
    endfunction

    function void note_request(input logic [127:0] pt, input logic start);
      logic [127:0] ct;
      logic [127:0] ks;
      logic [7:0]   cb;
      if (start) chain = iv;
      if (mode == aes128_pkg::MODE_CBC) begin
        ct = cipher_block128(pt ^ chain, key);
        chain = ct;
      end else if (mode == aes128_pkg::MODE_CFB) begin
        for (int i = 0; i < 16; i++) begin
          ks = cipher_block128(chain, key);
          cb = pt[127 - 8 * i -: 8] ^ ks[127:120];
          ct[127 - 8 * i -: 8] = cb;
          chain = {chain[119:0], cb};
        end
      end else begin
        ct = cipher_block128(pt, key);
      end
      pending_cipher.push_back(ct);
    endfunction

    function void check_result(input logic [127:0] got);
      logic [127:0] exp_ct;
      if (pending_cipher.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      exp_ct = pending_cipher.pop_front();
      if (got[127:64] !== exp_ct[127:64]) begin
        errors++;
        $display("%0t: cipher_hi expected %h actual %h", $time, exp_ct[127:64], got[127:64]);
      end
      if (got[63:0] !== exp_ct[63:0]) begin
        errors++;
        $display("%0t: cipher_lo expected %h actual %h", $time, exp_ct[63:0], got[63:0]);
      end
    endfunction
  endclass
endpackage

module aes128_block_mode_encrypt_core_test;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // [63:0] block_hi, [127:64] block_lo
  logic         in_tuser = 1'b0; // start_of_message
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // [63:0] cipher_hi, [127:64] cipher_lo
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  aes128_tb_model_pkg::cipher_scoreboard sb = new();

  int send_idle_pct = 13;  // chance in a hundred that the sender skips a cycle
  int recv_idle_pct = 70;  // same for the receiver
  bit hold_out = 1'b0;     // main flow asks for one long receiver stall
  int hold_cnt = 0;

  aes128_block_mode_encrypt_core DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random back-pressure; a long hold-off is counted here so the
  // sender keeps offering requests while the core sits full.
  always @(posedge clk) begin
    if (hold_out && hold_cnt == 0) begin
      hold_cnt <= 400;
      hold_out <= 1'b0;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor; the model keeps byte 0 on top
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tdata[63:0], out_tdata[127:64]});
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One config write; the channel drops for a cycle after each request.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [127:0] key,
                           input logic [127:0] iv);
    write_reg(aes128_pkg::CFG_MODE, {62'd0, mode});
    write_reg(aes128_pkg::CFG_KEY_HI, key[127:64]);
    write_reg(aes128_pkg::CFG_KEY_LO, key[63:0]);
    write_reg(aes128_pkg::CFG_IV_HI, iv[127:64]);
    write_reg(aes128_pkg::CFG_IV_LO, iv[63:0]);
  endtask

  // in_tvalid is only lowered on a gap, so back-to-back requests never
  // see a low and a high scheduled in the same step.
  task automatic send_block(input logic [127:0] pt, input logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pt[63:0], pt[127:64]};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(pt, start);
  endtask

  // Wait until every predicted ciphertext has come back, then let the core settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cipher.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int items);
    int left;
    int msg_len;
    drain();
    configure(2'($urandom_range(3)), {rand_word(), rand_word()},
              {rand_word(), rand_word()});
    if ($urandom_range(3) == 0)
      write_reg(3'(aes128_pkg::CFG_IV_LO + $urandom_range(1, 3)), rand_word());
    left = items;
    while (left > 0) begin
      msg_len = $urandom_range(1, 8);
      for (int i = 0; i < msg_len && left > 0; i++) begin
        // mostly well-formed messages; some stray start flags as noise
        send_block({rand_word(), rand_word()},
                   (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
        left--;
      end
      if ($urandom_range(9) == 0) drain();
    end
  endtask

  initial begin
    #10_000_000;
    $display("aes128_block_mode_encrypt_core: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // CBC with no start ever seen: chaining starts from the reset zero
    configure(aes128_pkg::MODE_CBC, 128'h000102030405060708090a0b0c0d0e0f, '1);
    send_block(128'h00112233445566778899aabbccddeeff, 1'b0);
    send_block('1, 1'b0);
    send_block('0, 1'b1);
    send_block(128'h8000000000000001_8000000000000001, 1'b0);

    // ECB, all-zero key; start flag still loads the IV
    drain();
    configure(aes128_pkg::MODE_ECB, '0, 128'h0123456789abcdef_fedcba9876543210);
    send_block('0, 1'b0);
    send_block('1, 1'b1);
    send_block(128'h00112233445566778899aabbccddeeff, 1'b0);

    // ECB ignored the chain; switch to CFB mid-message and continue from it
    drain();
    write_reg(aes128_pkg::CFG_MODE, {62'd0, aes128_pkg::MODE_CFB});
    send_block('0, 1'b0);
    send_block('1, 1'b0);

    // CFB with all-ones key and IV
    drain();
    configure(aes128_pkg::MODE_CFB, '1, '1);
    send_block('1, 1'b1);
    send_block('0, 1'b0);
    send_block(128'h00112233445566778899aabbccddeeff, 1'b1);

    // out-of-range indexes are ignored
    drain();
    write_reg(3'(aes128_pkg::CFG_IV_LO + 1), '1);
    write_reg(3'd6, 64'h5555aaaa5555aaaa);
    write_reg(3'd7, '1);

    // mode three behaves as ECB and leaves the chain alone
    write_reg(aes128_pkg::CFG_MODE, 64'd3);
    send_block('1, 1'b0);
    send_block('0, 1'b1);
    drain();
    write_reg(aes128_pkg::CFG_MODE, {62'd0, aes128_pkg::MODE_CBC});
    send_block('0, 1'b0);
    send_block('1, 1'b0);

    // receiver stalls long while the sender keeps pushing requests
    drain();
    hold_out <= 1'b1;
    for (int i = 0; i < 4; i++) send_block({rand_word(), rand_word()}, 1'b0);

    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 13 : (regime == 1) ? 70 : 0;
      recv_idle_pct = (regime == 0) ? 70 : (regime == 1) ? 13 : 0;
      for (int p = 0; p < 14; p++) random_phase(40);
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("aes128_block_mode_encrypt_core: match");
    end else begin
      $display("aes128_block_mode_encrypt_core: mismatch");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_ctrl.sv
hw/rtl/aes128_dp.sv
hw/rtl/aes128_block_mode_encrypt_core.sv
tb/aes128_block_mode_encrypt_core_test.sv
